[sv/mclb_pkg.sv]
package mclb_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int TIME_BITS    = 16;
    localparam int REPEAT_BITS  = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int REPORT_BITS  = 8;

    localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic [REPEAT_BITS-1:0] REPEAT_FOREVER = '1;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam logic REG_ACTIVE_HIGH_MASK = 1'b0;

    typedef enum logic [1:0] {
        PH_LIT  = 2'd0,
        PH_DARK = 2'd1,
        PH_IDLE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_DARK,
        CMD_STEADY,
        CMD_BLINK,
        CMD_STORE_DARK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [2:0]             channel;
        logic [TIME_BITS-1:0]   on_time;
        logic [TIME_BITS-1:0]   off_time;
        logic [REPEAT_BITS-1:0] repeat_count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [TIME_BITS-1:0] clamp_time(input logic [15:0] t);
        logic [63:0] w;
        w = {48'd0, t};
        if (w > TIME_MAX) begin
            return TIME_MAX[TIME_BITS-1:0];
        end
        return w[TIME_BITS-1:0];
    endfunction

endpackage

[sv/multi_channel_led_blinker.sv]
// Multi-channel LED blinker.
// Input stream s_*: one item per 1 ms tick, set command or stop command,
// action in s_tuser, channel and times in s_tdata. Every accepted item
// yields exactly one result item on m_*: pin levels after polarity in
// m_tdata[7:0] and the blinking-channel mask in m_tdata[15:8].
// An accepted item is decoded and placed in a two-entry command queue;
// the channel engine takes one command per cycle, updates all channel
// timers in parallel and registers the result. An item waits in a queue
// entry before its result is registered and m_tvalid rises; sustained rate
// is one item per cycle while m_tready is high.
// When m_tready is low with a result pending, the result holds, the engine
// stops, the queue fills and s_tready drops once both entries are taken.
// The APB port holds active_high_mask at address 0; write it only while
// no item is in flight.
// Reset (aresetn low, synchronous): all channels idle and dark, queue and
// result empty, active_high_mask back to all ones.
module multi_channel_led_blinker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // action
    input  logic [55:0] s_tdata,   // channel, on_time, off_time, repeat_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // led_levels, busy_mask
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 push;
    logic                 pop;
    mclb_pkg::cmd_t       push_cmd;
    mclb_pkg::cmd_t       head_cmd;
    mclb_pkg::q_status_t  q_status;
    logic [7:0]           mask_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 8'hFF;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mclb_pkg::REG_ACTIVE_HIGH_MASK) begin
            mask_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == mclb_pkg::REG_ACTIVE_HIGH_MASK) begin
            prdata = {24'd0, mask_reg};
        end
    end

    mclb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    mclb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    mclb_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_cmd         (head_cmd),
        .q_status         (q_status),
        .pop              (pop),
        .active_high_mask (mask_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

[sv/mclb_front.sv]
module mclb_front (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [1:0]              s_tuser,   // action
    input  logic [55:0]             s_tdata,   // channel, on_time, off_time, repeat_count
    input  mclb_pkg::q_status_t     q_status,
    output logic                    push,
    output mclb_pkg::cmd_t          cmd
);

    logic [2:0]  channel;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [15:0] repeat_count;
    logic        in_range;

    assign channel      = s_tdata[2:0];
    assign on_time      = s_tdata[18:3];
    assign off_time     = s_tdata[34:19];
    assign repeat_count = s_tdata[50:35];
    assign in_range     = int'(channel) < mclb_pkg::NUM_CHANNELS;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb begin
        cmd.channel      = channel;
        cmd.on_time      = mclb_pkg::clamp_time(on_time);
        cmd.off_time     = mclb_pkg::clamp_time(off_time);
        cmd.repeat_count = repeat_count[mclb_pkg::REPEAT_BITS-1:0];
        cmd.kind         = mclb_pkg::CMD_NOP;
        unique case (s_tuser)
            mclb_pkg::ACT_TICK: begin
                cmd.kind = mclb_pkg::CMD_TICK;
            end
            mclb_pkg::ACT_SET: begin
                if (in_range) begin
                    if (on_time == 16'd0) begin
                        cmd.kind = mclb_pkg::CMD_DARK;
                    end else if (off_time == 16'd0) begin
                        cmd.kind = mclb_pkg::CMD_STEADY;
                    end else if (repeat_count != 16'd0) begin
                        cmd.kind = mclb_pkg::CMD_BLINK;
                    end else begin
                        cmd.kind = mclb_pkg::CMD_STORE_DARK;
                    end
                end
            end
            mclb_pkg::ACT_STOP: begin
                if (in_range) begin
                    cmd.kind = mclb_pkg::CMD_DARK;
                end
            end
            default: begin
                cmd.kind = mclb_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

[sv/mclb_queue.sv]
module mclb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mclb_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output mclb_pkg::cmd_t      head_cmd,
    output mclb_pkg::q_status_t status
);

    mclb_pkg::cmd_t                 entries_reg [mclb_pkg::QUEUE_DEPTH];
    logic [mclb_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mclb_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mclb_pkg::QCNT_W-1:0]    count_reg;
    logic [mclb_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [mclb_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [mclb_pkg::QCNT_W-1:0]    count_next;
    logic                           do_push;
    logic                           do_pop;

    assign status.full  = count_reg == mclb_pkg::QCNT_W'(mclb_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == mclb_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == mclb_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/mclb_back.sv]
module mclb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  mclb_pkg::cmd_t      head_cmd,
    input  mclb_pkg::q_status_t q_status,
    output logic                pop,
    input  logic [7:0]          active_high_mask,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata    // led_levels, busy_mask
);

    localparam int N  = mclb_pkg::NUM_CHANNELS;
    localparam int TB = mclb_pkg::TIME_BITS;
    localparam int RB = mclb_pkg::REPEAT_BITS;

    mclb_pkg::phase_t phase_reg   [N];
    mclb_pkg::phase_t phase_next  [N];
    logic [N-1:0]     lit_reg;
    logic [N-1:0]     lit_next;
    logic [TB-1:0]    elapsed_reg [N];
    logic [TB-1:0]    elapsed_next[N];
    logic [TB-1:0]    on_reg      [N];
    logic [TB-1:0]    on_next     [N];
    logic [TB-1:0]    off_reg     [N];
    logic [TB-1:0]    off_next    [N];
    logic [RB-1:0]    rep_reg     [N];
    logic [RB-1:0]    rep_next    [N];
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic [7:0]       levels;
    logic [7:0]       busy;

    assign pop      = !q_status.empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        logic          sel;
        logic [TB-1:0] len;
        logic [TB-1:0] e1;
        for (int c = 0; c < N; c++) begin
            phase_next[c]   = phase_reg[c];
            lit_next[c]     = lit_reg[c];
            elapsed_next[c] = elapsed_reg[c];
            on_next[c]      = on_reg[c];
            off_next[c]     = off_reg[c];
            rep_next[c]     = rep_reg[c];
            sel = int'(head_cmd.channel) == c;
            len = (phase_reg[c] == mclb_pkg::PH_LIT) ? on_reg[c] : off_reg[c];
            e1  = elapsed_reg[c] + 1'b1;
            if (pop) begin
                case (head_cmd.kind)
                    mclb_pkg::CMD_TICK: begin
                        if (phase_reg[c] != mclb_pkg::PH_IDLE) begin
                            if (e1 < len) begin
                                elapsed_next[c] = e1;
                            end else begin
                                elapsed_next[c] = '0;
                                if (phase_reg[c] == mclb_pkg::PH_LIT) begin
                                    lit_next[c] = 1'b0;
                                    if (rep_reg[c] == mclb_pkg::REPEAT_FOREVER) begin
                                        phase_next[c] = mclb_pkg::PH_DARK;
                                    end else if (rep_reg[c] > RB'(1)) begin
                                        rep_next[c]   = rep_reg[c] - 1'b1;
                                        phase_next[c] = mclb_pkg::PH_DARK;
                                    end else begin
                                        phase_next[c] = mclb_pkg::PH_IDLE;
                                    end
                                end else begin
                                    phase_next[c] = mclb_pkg::PH_LIT;
                                    lit_next[c]   = 1'b1;
                                end
                            end
                        end
                    end
                    mclb_pkg::CMD_DARK: begin
                        if (sel) begin
                            phase_next[c] = mclb_pkg::PH_IDLE;
                            lit_next[c]   = 1'b0;
                        end
                    end
                    mclb_pkg::CMD_STEADY: begin
                        if (sel) begin
                            phase_next[c] = mclb_pkg::PH_IDLE;
                            lit_next[c]   = 1'b1;
                        end
                    end
                    mclb_pkg::CMD_BLINK: begin
                        if (sel) begin
                            on_next[c]      = head_cmd.on_time;
                            off_next[c]     = head_cmd.off_time;
                            rep_next[c]     = head_cmd.repeat_count;
                            phase_next[c]   = mclb_pkg::PH_LIT;
                            lit_next[c]     = 1'b1;
                            elapsed_next[c] = '0;
                        end
                    end
                    mclb_pkg::CMD_STORE_DARK: begin
                        if (sel) begin
                            on_next[c]    = head_cmd.on_time;
                            off_next[c]   = head_cmd.off_time;
                            rep_next[c]   = head_cmd.repeat_count;
                            phase_next[c] = mclb_pkg::PH_IDLE;
                            lit_next[c]   = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        levels = '0;
        busy   = '0;
        for (int c = 0; c < mclb_pkg::REPORT_BITS; c++) begin
            if (c < N) begin
                levels[c] = lit_next[c] ? active_high_mask[c] : !active_high_mask[c];
                busy[c]   = phase_next[c] != mclb_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < N; c++) begin
                phase_reg[c]   <= mclb_pkg::PH_IDLE;
                elapsed_reg[c] <= '0;
                on_reg[c]      <= '0;
                off_reg[c]     <= '0;
                rep_reg[c]     <= '0;
            end
            lit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            for (int c = 0; c < N; c++) begin
                phase_reg[c]   <= phase_next[c];
                elapsed_reg[c] <= elapsed_next[c];
                on_reg[c]      <= on_next[c];
                off_reg[c]     <= off_next[c];
                rep_reg[c]     <= rep_next[c];
            end
            lit_reg <= lit_next;
            if (pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= {busy, levels};
        end
    end

endmodule
